[hdl/dmp_pkg.sv]
// ----------------------------------------------------------------------------
// Depth map pseudocolor package
// Shared types, register codes and constants for the pseudocolor block.
// ----------------------------------------------------------------------------
package dmp_pkg;

    // Configuration port geometry.
    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = 2;
    localparam int DATA_W    = 32;

    // Register indexes within the configuration space.
    localparam logic [REG_IDX_W-1:0] REG_COLOUR_MODE  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_NEAR_LIMIT   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_FAR_LIMIT    = 2'd3;

    // Register field widths.
    localparam int MODE_W   = 2;
    localparam int HEIGHT_W = 11;
    localparam int LIMIT_W  = 16;

    // Color modes.
    localparam logic [MODE_W-1:0] MODE_RAW   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GRAY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIXED = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ROW   = 2'd3;

    // Register reset values.
    localparam logic [MODE_W-1:0]   RST_COLOUR_MODE  = MODE_FIXED;
    localparam logic [HEIGHT_W-1:0] RST_FRAME_HEIGHT = 11'd480;
    localparam logic [LIMIT_W-1:0]  RST_NEAR_LIMIT   = 16'd850;
    localparam logic [LIMIT_W-1:0]  RST_FAR_LIMIT    = 16'd1200;

    // Operation codes of an input word.
    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    // Level and band arithmetic.
    localparam int QUOT_BITS = 8;
    localparam int CNT_W     = 3;
    localparam int ROWN_W    = HEIGHT_W + 7;
    localparam logic [QUOT_BITS-1:0] LEVEL_MAX  = 8'd255;
    localparam logic [6:0]           ROW_SCALE  = 7'd100;
    localparam logic [LIMIT_W-1:0]   BAND_BASE  = 16'd700;
    localparam logic [LIMIT_W-1:0]   BAND_SPAN  = 16'd400;
    localparam logic [31:0]          PIX_WHITE  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [MODE_W-1:0]   colour_mode;
        logic [HEIGHT_W-1:0] frame_height;
        logic [LIMIT_W-1:0]  near_limit;
        logic [LIMIT_W-1:0]  far_limit;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic measure;
        logic start;
        logic step;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;
    } status_t;

endpackage

[hdl/dmp_regs.sv]
// ----------------------------------------------------------------------------
// Depth map pseudocolor configuration registers
// APB-style register file holding the color mode, frame height and limits.
// ----------------------------------------------------------------------------
module dmp_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dmp_pkg::ADDR_W-1:0]  paddr,
    input  logic [dmp_pkg::DATA_W-1:0]  pwdata,
    output logic [dmp_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output dmp_pkg::cfg_t               cfg
);
    import dmp_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx    = paddr[REG_IDX_W+1:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_COLOUR_MODE:  cfg_next.colour_mode  = pwdata[MODE_W-1:0];
                REG_FRAME_HEIGHT: cfg_next.frame_height = pwdata[HEIGHT_W-1:0];
                REG_NEAR_LIMIT:   cfg_next.near_limit   = pwdata[LIMIT_W-1:0];
                REG_FAR_LIMIT:    cfg_next.far_limit    = pwdata[LIMIT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.colour_mode  <= RST_COLOUR_MODE;
            cfg_reg.frame_height <= RST_FRAME_HEIGHT;
            cfg_reg.near_limit   <= RST_NEAR_LIMIT;
            cfg_reg.far_limit    <= RST_FAR_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (idx)
            REG_COLOUR_MODE:  prdata = DATA_W'(cfg_reg.colour_mode);
            REG_FRAME_HEIGHT: prdata = DATA_W'(cfg_reg.frame_height);
            REG_NEAR_LIMIT:   prdata = DATA_W'(cfg_reg.near_limit);
            REG_FAR_LIMIT:    prdata = DATA_W'(cfg_reg.far_limit);
            default:          prdata = '0;
        endcase
    end

endmodule

[hdl/dmp_ctrl.sv]
// ----------------------------------------------------------------------------
// Depth map pseudocolor controller
// Sequences acceptance, the division steps and delivery of one result word.
// ----------------------------------------------------------------------------
module dmp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_operation,
    output logic              s_ready,
    input  dmp_pkg::status_t  status,
    output dmp_pkg::cmd_t     cmd
);
    import dmp_pkg::*;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_DIVIDE  = 2'd1;
    localparam logic [1:0] ST_DELIVER = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        cmd         = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_operation == OP_MEASURE) begin
                        cmd.measure = 1'b1;
                    end else begin
                        cmd.start  = 1'b1;
                        count_next = CNT_W'(QUOT_BITS - 1);
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE: begin
                cmd.step = 1'b1;
                if (count_reg == '0) begin
                    state_next = ST_DELIVER;
                end else begin
                    count_next = count_reg - 1'b1;
                end
            end
            ST_DELIVER: begin
                // The result waits here until the output register frees up.
                if (!status.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule

[hdl/dmp_datapath.sv]
// ----------------------------------------------------------------------------
// Depth map pseudocolor datapath
// Maximum tracker, two shift-subtract dividers, color build and output word.
// ----------------------------------------------------------------------------
module dmp_datapath #(
    parameter int DEPTH_BITS = 16,
    parameter int ROW_BITS   = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dmp_pkg::cmd_t          cmd,
    input  dmp_pkg::cfg_t          cfg,
    input  logic [DEPTH_BITS-1:0]  s_depth,
    input  logic [ROW_BITS-1:0]    s_row_index,
    input  logic                   s_pass_end,
    output dmp_pkg::status_t       status,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [31:0]            m_pixel_colour,
    output logic                   m_frame_last
);
    import dmp_pkg::*;

    localparam int PW = DEPTH_BITS + QUOT_BITS;
    localparam int RW = (ROW_BITS > HEIGHT_W) ? ROW_BITS : HEIGHT_W;

    // Maximum tracker.
    logic [DEPTH_BITS-1:0] run_max_reg,   run_max_next;
    logic [DEPTH_BITS-1:0] frame_max_reg, frame_max_next;
    logic [DEPTH_BITS-1:0] meas_max;

    // Operands held for one convert word.
    logic [DEPTH_BITS-1:0] depth_reg;
    logic                  last_reg;
    logic                  sat_reg;
    logic                  zero_reg;
    logic                  row_hit_reg;

    // Level divider: depth*255 / frame maximum.
    logic [DEPTH_BITS-1:0] lrem_reg,  lrem_next;
    logic [QUOT_BITS-1:0]  lbits_reg, lbits_next;
    logic [QUOT_BITS-1:0]  lquo_reg,  lquo_next;
    logic [PW-1:0]         lprod;
    logic [DEPTH_BITS:0]   ltrial;
    logic                  lge;

    // Row divider: 100*(height-row) / height.
    logic [HEIGHT_W-1:0]   rrem_reg,  rrem_next;
    logic [QUOT_BITS-1:0]  rbits_reg, rbits_next;
    logic [QUOT_BITS-1:0]  rquo_reg,  rquo_next;
    logic [HEIGHT_W-1:0]   rdiff;
    logic [ROWN_W-1:0]     rprod;
    logic [HEIGHT_W:0]     rtrial;
    logic                  rge;
    logic                  row_hit;

    // Color build and output word.
    logic [QUOT_BITS-1:0]  level;
    logic [LIMIT_W-1:0]    depth_w;
    logic [LIMIT_W-1:0]    lo_lim;
    logic [LIMIT_W-1:0]    hi_lim;
    logic [31:0]           band_pix;
    logic [31:0]           pix;
    logic                  out_valid_reg, out_valid_next;
    logic [31:0]           pix_reg;
    logic                  out_last_reg;

    assign meas_max = (s_depth > run_max_reg) ? s_depth : run_max_reg;

    always_comb begin
        run_max_next   = run_max_reg;
        frame_max_next = frame_max_reg;
        if (cmd.measure) begin
            if (s_pass_end) begin
                frame_max_next = meas_max;
                run_max_next   = '0;
            end else begin
                run_max_next   = meas_max;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_max_reg   <= '0;
            frame_max_reg <= '0;
        end else begin
            run_max_reg   <= run_max_next;
            frame_max_reg <= frame_max_next;
        end
    end

    // When the depth reaches the maximum the level saturates, so the divider
    // only has to produce quotients below 256.
    assign lprod   = (PW'(s_depth) << QUOT_BITS) - PW'(s_depth);
    assign ltrial  = {lrem_reg, lbits_reg[QUOT_BITS-1]};
    assign lge     = (ltrial >= (DEPTH_BITS+1)'(frame_max_reg));

    assign row_hit = (RW'(s_row_index) < RW'(cfg.frame_height));
    assign rdiff   = HEIGHT_W'(RW'(cfg.frame_height) - RW'(s_row_index));
    assign rprod   = ROWN_W'(rdiff) * ROWN_W'(ROW_SCALE);
    assign rtrial  = {rrem_reg, rbits_reg[QUOT_BITS-1]};
    assign rge     = (rtrial >= (HEIGHT_W+1)'(cfg.frame_height));

    always_comb begin
        lrem_next  = lrem_reg;
        lbits_next = lbits_reg;
        lquo_next  = lquo_reg;
        rrem_next  = rrem_reg;
        rbits_next = rbits_reg;
        rquo_next  = rquo_reg;
        if (cmd.start) begin
            lrem_next  = lprod[PW-1:QUOT_BITS];
            lbits_next = lprod[QUOT_BITS-1:0];
            lquo_next  = '0;
            rrem_next  = HEIGHT_W'(rprod[ROWN_W-1:QUOT_BITS]);
            rbits_next = rprod[QUOT_BITS-1:0];
            rquo_next  = '0;
        end else if (cmd.step) begin
            lrem_next  = lge ? DEPTH_BITS'(ltrial - (DEPTH_BITS+1)'(frame_max_reg))
                             : DEPTH_BITS'(ltrial);
            lbits_next = lbits_reg << 1;
            lquo_next  = {lquo_reg[QUOT_BITS-2:0], lge};
            rrem_next  = rge ? HEIGHT_W'(rtrial - (HEIGHT_W+1)'(cfg.frame_height))
                             : HEIGHT_W'(rtrial);
            rbits_next = rbits_reg << 1;
            rquo_next  = {rquo_reg[QUOT_BITS-2:0], rge};
        end
    end

    always_ff @(posedge aclk) begin
        lrem_reg  <= lrem_next;
        lbits_reg <= lbits_next;
        lquo_reg  <= lquo_next;
        rrem_reg  <= rrem_next;
        rbits_reg <= rbits_next;
        rquo_reg  <= rquo_next;
        if (cmd.start) begin
            depth_reg   <= s_depth;
            last_reg    <= s_pass_end;
            sat_reg     <= (s_depth >= frame_max_reg);
            zero_reg    <= (frame_max_reg == '0);
            row_hit_reg <= row_hit;
        end
    end

    always_comb begin
        if (zero_reg) begin
            level = '0;
        end else if (sat_reg) begin
            level = LEVEL_MAX;
        end else begin
            level = lquo_reg;
        end
    end

    assign depth_w = LIMIT_W'(depth_reg);

    always_comb begin
        if (cfg.colour_mode == MODE_ROW) begin
            lo_lim = BAND_BASE + (row_hit_reg ? LIMIT_W'(rquo_reg) : '0);
            hi_lim = lo_lim + BAND_SPAN;
        end else begin
            lo_lim = cfg.near_limit;
            hi_lim = cfg.far_limit;
        end
    end

    always_comb begin
        if (depth_w == '0) begin
            band_pix = PIX_WHITE;
        end else if (depth_w <= lo_lim) begin
            band_pix = 32'(level);
        end else if (depth_w <= hi_lim) begin
            band_pix = 32'(level) << 8;
        end else begin
            band_pix = 32'(level) << 16;
        end
    end

    always_comb begin
        case (cfg.colour_mode)
            MODE_RAW:   pix = 32'(depth_reg);
            MODE_GRAY:  pix = {8'h00, level, level, level};
            MODE_FIXED: pix = band_pix;
            MODE_ROW:   pix = band_pix;
            default:    pix = band_pix;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.finish) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            pix_reg      <= pix;
            out_last_reg <= last_reg;
        end
    end

    assign status.out_busy = out_valid_reg & ~m_ready;
    assign m_valid         = out_valid_reg;
    assign m_pixel_colour  = pix_reg;
    assign m_frame_last    = out_last_reg;

endmodule

[hdl/depth_map_pseudocolor.sv]
// ----------------------------------------------------------------------------
// Depth map pseudocolor
// Turns a depth frame, sent twice, into 32-bit color words.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                            Direction
//  -------   ----------------------------------------------   ---------
//  input     s_valid/s_ready, s_operation, s_depth,           in
//            s_row_index, s_pass_end
//  result    m_valid/m_ready, m_pixel_colour, m_frame_last    out
//  config    psel, penable, pwrite, paddr, pwdata,            in/out
//            prdata, pready
//
//  A measure word yields no result. A convert word is loaded into the output
//  register after its acceptance: the accepting edge latches the operands,
//  the controller then runs the restoring division loop one quotient bit at a
//  time, and once the output register is free the color is built and loaded.
//  The next word can be accepted once the controller is back in idle.
//  Reset (aresetn low at a clock edge) restores the register defaults and
//  clears the running and frame maximum. A stalled result holds the output
//  register, and the controller then waits with the next result until the
//  register is taken; input words are accepted only while the controller is
//  idle.
//
// The frame is presented twice. In the measure pass the datapath keeps a
// running maximum of the depth, and the word marked as the end of the pass
// latches that maximum (including its own depth) as the frame maximum, then
// clears the running maximum for the next frame. In the convert pass every
// word produces one color word from level = depth*255/maximum, which is zero
// when the maximum is zero and saturates at 255 when the depth reaches the
// maximum. The band modes pick blue, green or red by the near and far limits;
// the row-adjusted mode derives those limits from the row position through
// a second divider that runs alongside the level divider.
//
module depth_map_pseudocolor #(
    parameter int DEPTH_BITS = 16,
    parameter int ROW_BITS   = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_operation,
    input  logic [DEPTH_BITS-1:0]       s_depth,
    input  logic [ROW_BITS-1:0]         s_row_index,
    input  logic                        s_pass_end,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [31:0]                 m_pixel_colour,
    output logic                        m_frame_last,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dmp_pkg::ADDR_W-1:0]  paddr,
    input  logic [dmp_pkg::DATA_W-1:0]  pwdata,
    output logic [dmp_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import dmp_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    // Register file on the configuration port.
    dmp_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The controller owns the input handshake and the division step count.
    dmp_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .s_ready     (s_ready),
        .status      (status),
        .cmd         (cmd)
    );

    // The datapath holds the maximum tracker, both dividers and the output
    // register that drives the result channel.
    dmp_datapath #(
        .DEPTH_BITS (DEPTH_BITS),
        .ROW_BITS   (ROW_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .cfg            (cfg),
        .s_depth        (s_depth),
        .s_row_index    (s_row_index),
        .s_pass_end     (s_pass_end),
        .status         (status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_colour (m_pixel_colour),
        .m_frame_last   (m_frame_last)
    );

    // Only one command is issued in any cycle.
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.measure, cmd.start, cmd.step, cmd.finish}))
        else $error("more than one datapath command in a cycle");

    // An accepted convert word keeps the block busy in the following cycle.
    a_convert_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_operation == OP_CONVERT) |=> !s_ready)
        else $error("input accepted while a convert word is in progress");

    // Loading a result always presents it on the result channel next cycle.
    a_finish_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_valid)
        else $error("result loaded but not presented");

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !(m_valid && !m_ready))
        else $error("pending result overwritten");

endmodule
